>>> rtl/btcr_pkg.sv
// Package for the battery time and charge report unit.
// Holds register indexes, reset values, widths and the sideband type.
// No dependencies.
`timescale 1ns / 1ps
package btcr_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_LOOSE_LOW  = 3'd0;
	localparam logic [2:0] REG_LOOSE_HIGH = 3'd1;
	localparam logic [2:0] REG_MAX_MIN    = 3'd2;
	localparam logic [2:0] REG_RESERVE    = 3'd3;
	localparam logic [2:0] REG_GOOD_PCT   = 3'd4;

	localparam logic [15:0] RST_LOOSE_LOW  = 16'd5;
	localparam logic [15:0] RST_LOOSE_HIGH = 16'd15000;
	localparam logic [9:0]  RST_MAX_MIN    = 10'd600;
	localparam logic [11:0] RST_RESERVE    = 12'd200;
	localparam logic [6:0]  RST_GOOD_PCT   = 7'd80;

	localparam int ADDR_W = 5;
	// Numerator and divisor widths shared by both divider chains.
	localparam int NUM_W = 24;
	localparam int DIV_W = 17;

	localparam logic [10:0] EST_UNKNOWN = 11'h7FF;
	localparam logic [1:0] HEALTH_NONE = 2'd0;
	localparam logic [1:0] HEALTH_GOOD = 2'd1;
	localparam logic [1:0] HEALTH_FAIR = 2'd2;
	localparam logic [1:0] HEALTH_POOR = 2'd3;

	// Flags that travel beside the time quotient.
	typedef struct packed {
		logic force_unknown;
		logic neg;
		logic present;
		logic chg;
		logic ext;
		logic fail;
		logic capdata;
		logic good;
	} side_t;

endpackage

>>> rtl/btcr_if.sv
// Valid/ready channel interfaces for the reading and the report items.
// No dependencies.
`timescale 1ns / 1ps
interface btcr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] avg_amperage;
	logic signed [15:0] instant_amperage;
	logic               has_instant;
	logic               is_charging;
	logic               on_external;
	logic               is_present;
	logic        [15:0] current_cap;
	logic        [15:0] max_cap;
	logic        [15:0] design_cap;
	logic               has_capacity_data;
	logic               perm_failure;
	modport source (output valid, avg_amperage, instant_amperage, has_instant, is_charging,
		on_external, is_present, current_cap, max_cap, design_cap, has_capacity_data,
		perm_failure, input ready);
	modport sink (input valid, avg_amperage, instant_amperage, has_instant, is_charging,
		on_external, is_present, current_cap, max_cap, design_cap, has_capacity_data,
		perm_failure, output ready);
endinterface

interface btcr_out_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] time_to_full;
	logic signed [10:0] time_to_empty;
	logic               charging;
	logic        [7:0]  charge_percent;
	logic        [6:0]  capacity_percent;
	logic        [1:0]  health;
	modport source (output valid, time_to_full, time_to_empty, charging, charge_percent,
		capacity_percent, health, input ready);
	modport sink (input valid, time_to_full, time_to_empty, charging, charge_percent,
		capacity_percent, health, output ready);
endinterface

>>> rtl/btcr_div_cell.sv
// One restoring division cell: settles one quotient bit and passes on.
// No dependencies.
`timescale 1ns / 1ps
module btcr_div_cell #(
	parameter int NW = 24,
	parameter int DW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [NW-1:0] in_nq,
	input  logic [DW-1:0] in_d,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [DW-1:0] out_rem,
	output logic [NW-1:0] out_nq,
	output logic [DW-1:0] out_d,
	output logic [SW-1:0] out_side
);
	logic          valid_q;
	logic [DW-1:0] rem_q, d_q;
	logic [NW-1:0] nq_q;
	logic [SW-1:0] side_q;
	logic [DW:0]   trial;
	logic          fits;

	// Bring down the next numerator bit and try the subtraction.
	assign trial = {in_rem, in_nq[NW-1]};
	assign fits  = trial >= {1'b0, in_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// The numerator shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= fits ? DW'(trial - {1'b0, in_d}) : trial[DW-1:0];
			nq_q   <= {in_nq[NW-2:0], fits};
			d_q    <= in_d;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_nq    = nq_q;
	assign out_d     = d_q;
	assign out_side  = side_q;
endmodule

>>> rtl/btcr_div_chain.sv
// A row of division cells, one per quotient bit.
// Depends on btcr_div_cell.
`timescale 1ns / 1ps
module btcr_div_chain #(
	parameter int NW = 24,
	parameter int DW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_d,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [NW-1:0] out_quot,
	output logic [SW-1:0] out_side
);
	logic          v   [NW+1];
	logic [DW-1:0] rem [NW+1];
	logic [NW-1:0] nq  [NW+1];
	logic [DW-1:0] d   [NW+1];
	logic [SW-1:0] sd  [NW+1];

	assign v[0]   = in_valid;
	assign rem[0] = '0;
	assign nq[0]  = in_num;
	assign d[0]   = in_d;
	assign sd[0]  = in_side;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		btcr_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v[k]), .in_rem(rem[k]), .in_nq(nq[k]), .in_d(d[k]), .in_side(sd[k]),
			.out_valid(v[k+1]), .out_rem(rem[k+1]), .out_nq(nq[k+1]), .out_d(d[k+1]),
			.out_side(sd[k+1])
		);
	end

	assign out_valid = v[NW];
	assign out_quot  = nq[NW];
	assign out_side  = sd[NW];
endmodule

>>> rtl/battery_time_and_charge_report_unit.sv
// Top level of the battery time and charge report unit.
// Depends on btcr_pkg, btcr_if and btcr_div_chain.
//
//   channel  | direction | handshake      | content
//   in_ch    | in        | valid / ready  | one battery reading
//   out_ch   | out       | valid / ready  | one report item
//   apb      | in        | psel / penable | five configuration registers
//
// One item is accepted per cycle while the output is not stalled; each passes one input stage,
// 24 division cells (one quotient bit each) and the output register.
// The whole pipeline holds while a finished item waits to be taken.
// Reset clears all valid flags and restores the register defaults.
`timescale 1ns / 1ps
module battery_time_and_charge_report_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	btcr_in_if.sink                     in_ch,
	btcr_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btcr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import btcr_pkg::*;

	logic [15:0] loose_low_q, loose_high_q;
	logic [9:0]  max_min_q;
	logic [11:0] reserve_q;
	logic [6:0]  good_pct_q;
	logic [2:0]  idx;
	logic        en;

	// Configuration registers.
	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loose_low_q  <= RST_LOOSE_LOW;
			loose_high_q <= RST_LOOSE_HIGH;
			max_min_q    <= RST_MAX_MIN;
			reserve_q    <= RST_RESERVE;
			good_pct_q   <= RST_GOOD_PCT;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_LOOSE_LOW:  loose_low_q  <= pwdata[15:0];
				REG_LOOSE_HIGH: loose_high_q <= pwdata[15:0];
				REG_MAX_MIN:    max_min_q    <= pwdata[9:0];
				REG_RESERVE:    reserve_q    <= pwdata[11:0];
				REG_GOOD_PCT:   good_pct_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LOOSE_LOW:  prdata = {16'd0, loose_low_q};
			REG_LOOSE_HIGH: prdata = {16'd0, loose_high_q};
			REG_MAX_MIN:    prdata = {22'd0, max_min_q};
			REG_RESERVE:    prdata = {20'd0, reserve_q};
			REG_GOOD_PCT:   prdata = {25'd0, good_pct_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Front logic: magnitudes, bounds, numerators and the health compare.
	logic [16:0] aavg, ainst, hnum;
	logic [15:0] adiff;
	logic        oob, full_zero_c;
	logic [23:0] nt_c, np_c;
	logic [16:0] dp_c;
	logic [23:0] hlhs;
	logic [22:0] hrhs;
	side_t       side_c;

	always_comb begin
		aavg  = in_ch.avg_amperage[15] ? 17'(-{1'b1, in_ch.avg_amperage})
			: {1'b0, in_ch.avg_amperage};
		ainst = in_ch.instant_amperage[15] ? 17'(-{1'b1, in_ch.instant_amperage})
			: {1'b0, in_ch.instant_amperage};
		if (in_ch.has_instant) begin
			oob = ({aavg, 1'b0} < {1'b0, ainst}) || ({1'b0, aavg} > {ainst, 1'b0});
		end else begin
			oob = (aavg < {1'b0, loose_low_q}) || (aavg > {1'b0, loose_high_q});
		end
		adiff = (in_ch.max_cap >= in_ch.current_cap) ? in_ch.max_cap - in_ch.current_cap
			: in_ch.current_cap - in_ch.max_cap;
		nt_c  = in_ch.is_charging ? 24'(adiff * 8'd60) : 24'(in_ch.current_cap * 8'd60);
		np_c  = 24'(in_ch.current_cap * 8'd200) + {8'd0, in_ch.max_cap};
		full_zero_c = in_ch.max_cap == 16'd0;
		dp_c  = full_zero_c ? 17'd1 : {in_ch.max_cap, 1'b0};
		hnum  = {1'b0, in_ch.max_cap} + {5'd0, reserve_q};
		hlhs  = 24'(hnum * 7'd100);
		hrhs  = 23'(good_pct_q * in_ch.design_cap);
		side_c.force_unknown = oob || (in_ch.avg_amperage == 16'sd0);
		side_c.neg = in_ch.avg_amperage[15] ^ (in_ch.is_charging
			? (in_ch.current_cap > in_ch.max_cap) : (in_ch.current_cap != 16'd0));
		side_c.present = in_ch.is_present;
		side_c.chg     = in_ch.is_charging;
		side_c.ext     = in_ch.on_external;
		side_c.fail    = in_ch.perm_failure;
		side_c.capdata = in_ch.has_capacity_data;
		side_c.good    = (in_ch.design_cap == 16'd0) ? (hnum != 17'd0)
			: ({1'b0, hrhs} <= hlhs);
	end

	// Input stage.
	logic        valid_s1, fz_s1;
	logic [23:0] nt_s1, np_s1;
	logic [16:0] dt_s1, dp_s1;
	side_t       side_s1;

	assign in_ch.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ch.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nt_s1   <= nt_c;
			np_s1   <= np_c;
			dt_s1   <= aavg;
			dp_s1   <= dp_c;
			fz_s1   <= full_zero_c;
			side_s1 <= side_c;
		end
	end

	// Division chains for the time estimate and the charge percentage.
	logic        vt, vp, fz_d;
	logic [23:0] qt, qp;
	side_t       side_d;

	btcr_div_chain #(.NW(NUM_W), .DW(DIV_W), .SW($bits(side_t))) u_time (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s1), .in_num(nt_s1),
		.in_d(dt_s1), .in_side(side_s1), .out_valid(vt), .out_quot(qt), .out_side(side_d)
	);
	btcr_div_chain #(.NW(NUM_W), .DW(DIV_W), .SW(1)) u_pct (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s1), .in_num(np_s1),
		.in_d(dp_s1), .in_side(fz_s1), .out_valid(vp), .out_quot(qp), .out_side(fz_d)
	);

	// Report assembly.
	logic [10:0] est, ttf_c, tte_c;
	logic [7:0]  pct_c;
	logic        chg_c;
	logic [1:0]  health_c;

	always_comb begin
		if (side_d.force_unknown || (side_d.neg && qt != 24'd0)) begin
			est = EST_UNKNOWN;
		end else if (qt > {14'd0, max_min_q}) begin
			est = {1'b0, max_min_q};
		end else begin
			est = qt[10:0];
		end
		if (fz_d) begin
			pct_c = 8'd0;
		end else if (qp == 24'd100 && side_d.chg) begin
			pct_c = 8'd99;
		end else if (qp > 24'd255) begin
			pct_c = 8'd255;
		end else begin
			pct_c = qp[7:0];
		end
		ttf_c = 11'd0;
		tte_c = 11'd0;
		chg_c = 1'b0;
		health_c = HEALTH_NONE;
		if (side_d.present) begin
			if (est == EST_UNKNOWN) begin
				chg_c = side_d.chg;
				ttf_c = EST_UNKNOWN;
				tte_c = EST_UNKNOWN;
			end else if (side_d.chg) begin
				chg_c = 1'b1;
				ttf_c = est;
			end else if (!side_d.ext) begin
				tte_c = est;
			end
			if (side_d.fail) begin
				health_c = HEALTH_POOR;
			end else if (side_d.capdata) begin
				health_c = side_d.good ? HEALTH_GOOD : HEALTH_FAIR;
			end
		end
	end

	// Output register.
	logic        out_valid_q, chg_q;
	logic [10:0] ttf_q, tte_q;
	logic [7:0]  pct_q;
	logic [6:0]  cap_q;
	logic [1:0]  health_q;

	assign en = !out_valid_q || out_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vt && vp;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ttf_q    <= ttf_c;
			tte_q    <= tte_c;
			chg_q    <= chg_c;
			pct_q    <= pct_c;
			cap_q    <= fz_d ? 7'd0 : 7'd100;
			health_q <= health_c;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.time_to_full     = ttf_q;
	assign out_ch.time_to_empty    = tte_q;
	assign out_ch.charging         = chg_q;
	assign out_ch.charge_percent   = pct_q;
	assign out_ch.capacity_percent = cap_q;
	assign out_ch.health           = health_q;

	// Both chains must move in lockstep.
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n) vt == vp)
		else $error("division chains out of step");
	// Only one time can hold a real estimate.
	a_one_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(ttf_q != 11'd0 && tte_q != 11'd0 && ttf_q != EST_UNKNOWN))
		else $error("both times carry an estimate");
	// Zero full capacity reports zero charge.
	a_zero_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && cap_q == 7'd0) |-> pct_q == 8'd0)
		else $error("charge reported without capacity");
	// A stalled output freezes the input stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> $stable(valid_s1))
		else $error("pipeline moved during stall");
endmodule
